### hw/rtl/sfr_pkg.sv
// Shared constants, codes and control types of the SLIP frame receiver.
package sfr_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int MAX_FRAME    = 32;
  localparam int STORE_DEPTH  = (BUFFER_BYTES < MAX_FRAME) ? BUFFER_BYTES : MAX_FRAME;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 6;
  localparam int LEN_W   = 5;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 3;
  localparam int LIMIT_W = 6;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
  localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
  localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
  localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd2;

  localparam logic [CODE_W-1:0] EV_BAD_ESCAPE = 3'd0;
  localparam logic [CODE_W-1:0] EV_UNEXP_END  = 3'd1;
  localparam logic [CODE_W-1:0] EV_SEQ_GAP    = 3'd2;
  localparam logic [CODE_W-1:0] EV_OVERFLOW   = 3'd3;
  localparam logic [CODE_W-1:0] EV_CHECKSUM   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_WARN     = 1'b1;

  localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST = 6'd32;

  typedef enum logic [1:0] {
    PH_AWAIT   = 2'd0,
    PH_READ    = 2'd1,
    PH_INVALID = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_SEND  = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic step;     // input transfer this cycle
    logic rd_load;  // move buffered byte into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or drained this cycle
    logic readout_go; // current byte closes a good frame with payload
    logic rd_last;    // readout index points at final payload byte
  } ctl_sts_t;

endpackage

### hw/rtl/sfr_byte_if.sv
// Received byte channel: valid/ready handshake with one raw byte.
interface sfr_byte_if
  import sfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/sfr_result_if.sv
// Result channel: valid/ready handshake with header, payload or event fields.
interface sfr_result_if
  import sfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] frame_sequence;
  logic [LEN_W-1:0]  payload_length;
  logic [BYTE_W-1:0] payload_byte;
  logic [CODE_W-1:0] event_code;
  logic              last_result;

  modport source (output valid, output result_kind, output frame_sequence,
                  output payload_length, output payload_byte, output event_code,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input frame_sequence,
                  input payload_length, input payload_byte, input event_code,
                  input last_result, output ready);
endinterface

### hw/rtl/slip_frame_receiver.sv
// Top level of the SLIP frame receiver: controller, datapath and checks.
// A received byte is taken whenever the output register is empty or is being drained; a
// byte that causes a result (an event, or the header of a frame) puts it in the output
// register on the next cycle. The END that closes a good frame is followed by its payload
// bytes, read from the 32-byte frame buffer RAM: each payload byte passes through the FETCH
// state (address) and the SEND state (registered read data into the output register) and
// waits out any output stall, and no byte is accepted until the last payload byte is
// loaded. The buffer needs no clearing after reset. Configuration writes take effect at
// the next clock edge.
module slip_frame_receiver
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sfr_byte_if.sink             in_ch,
  sfr_result_if.source         out_ch
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_rx_byte         (in_ch.rx_byte),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_result_kind    (out_ch.result_kind),
    .out_frame_sequence (out_ch.frame_sequence),
    .out_payload_length (out_ch.payload_length),
    .out_payload_byte   (out_ch.payload_byte),
    .out_event_code     (out_ch.event_code),
    .out_last_result    (out_ch.last_result),
    .cmd                (cmd),
    .sts                (sts)
  );

`ifndef SYNTHESIS
  // a frame with payload shows its header, not yet marked last
  a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.readout_go) |=>
      (out_ch.valid && out_ch.result_kind == KIND_HEADER && !out_ch.last_result))
    else $error("header missing ahead of payload readout");

  // buffer readout never overwrites a result still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_load |-> sts.out_free)
    else $error("payload load into occupied output register");

  // no input transfer while the buffer is being read out
  a_no_step_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_load |-> !cmd.step)
    else $error("input transfer during frame readout");

  // after the last payload byte is loaded, input is taken again once the output drains
  a_readout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_load && sts.rd_last) |=> (in_ch.ready == sts.out_free))
    else $error("receiver did not return to input after readout");
`endif

endmodule

### hw/rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sfr_ctrl.sv
// Controller FSM: input acceptance and frame buffer readout sequencing.
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && sts.out_free && sts.readout_go) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (sts.out_free) state_nxt = sts.rd_last ? S_IDLE : S_FETCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.step    = 1'b0;
    cmd.rd_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        cmd.step = in_valid && sts.out_free;
      end
      S_FETCH: begin
      end
      S_SEND: begin
        cmd.rd_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/sfr_datapath.sv
// Datapath: unescape, sequence and checksum tracking, frame buffer, result register.
module sfr_datapath
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [BYTE_W-1:0]    out_frame_sequence,
  output logic [LEN_W-1:0]     out_payload_length,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [CODE_W-1:0]    out_event_code,
  output logic                 out_last_result,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts
);

  // configuration
  logic [LIMIT_W-1:0] buffer_limit_r;
  logic               seq_warn_enable_r;

  // frame state
  phase_t             phase_r, phase_nxt;
  logic               escape_pending_r, escape_pending_nxt;
  logic [BYTE_W-1:0]  running_xor_r, running_xor_nxt;
  logic [BYTE_W-1:0]  expected_seq_r, expected_seq_nxt;
  logic [BYTE_W-1:0]  current_seq_r, current_seq_nxt;
  logic [FILL_W-1:0]  fill_count_r, fill_count_nxt;

  // readout
  logic [STORE_AW-1:0] rd_idx_r;
  logic [LEN_W-1:0]    frame_len_r;
  logic [BYTE_W-1:0]   rd_data;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [BYTE_W-1:0]  seq_r;
  logic [LEN_W-1:0]   len_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [CODE_W-1:0]  code_r;
  logic               last_r;

  // byte decode
  logic [FILL_W-1:0]  limit_use;
  logic [LEN_W-1:0]   frame_len;
  logic [BYTE_W-1:0]  byte_v;
  logic [BYTE_W-1:0]  xor_t;
  phase_t             phase_t_v;
  logic               do_phase;
  logic               store_we;
  logic               res_valid;
  logic [KIND_W-1:0]  res_kind;
  logic [CODE_W-1:0]  res_code;
  logic               res_last;
  logic               readout_go;

  assign limit_use = (buffer_limit_r > FILL_W'(STORE_DEPTH)) ? FILL_W'(STORE_DEPTH)
                                                              : buffer_limit_r;
  assign frame_len = LEN_W'(fill_count_r - FILL_W'(1));

  always_comb begin
    phase_nxt          = phase_r;
    escape_pending_nxt = escape_pending_r;
    running_xor_nxt    = running_xor_r;
    expected_seq_nxt   = expected_seq_r;
    current_seq_nxt    = current_seq_r;
    fill_count_nxt     = fill_count_r;
    byte_v             = in_rx_byte;
    xor_t              = running_xor_r;
    phase_t_v          = phase_r;
    do_phase           = 1'b0;
    store_we           = 1'b0;
    res_valid          = 1'b0;
    res_kind           = KIND_EVENT;
    res_code           = EV_BAD_ESCAPE;
    res_last           = 1'b1;
    readout_go         = 1'b0;

    if (escape_pending_r) begin
      escape_pending_nxt = 1'b0;
      do_phase           = 1'b1;
      if (in_rx_byte == SLIP_ESC_END) begin
        byte_v = SLIP_END;
      end else if (in_rx_byte == SLIP_ESC_ESC) begin
        byte_v = SLIP_ESC;
      end else begin
        res_valid = 1'b1;
        res_code  = EV_BAD_ESCAPE;
        phase_t_v = PH_INVALID;
      end
      xor_t = running_xor_r ^ byte_v;
    end else if (in_rx_byte == SLIP_ESC) begin
      escape_pending_nxt = 1'b1;
    end else if (in_rx_byte == SLIP_END) begin
      unique case (phase_r)
        PH_READ: begin
          if (running_xor_r == '0 && fill_count_r != '0) begin
            res_valid  = 1'b1;
            res_kind   = KIND_HEADER;
            res_last   = (frame_len == '0);
            readout_go = (frame_len != '0);
          end else begin
            res_valid       = 1'b1;
            res_code        = EV_CHECKSUM;
            running_xor_nxt = '0;
          end
          phase_nxt = PH_AWAIT;
        end
        PH_AWAIT: begin
          res_valid = 1'b1;
          res_code  = EV_UNEXP_END;
          phase_nxt = PH_INVALID;
        end
        default: begin
          // resync: END is not taken as the next sequence byte
          running_xor_nxt = '0;
          phase_nxt       = PH_AWAIT;
        end
      endcase
    end else begin
      xor_t    = running_xor_r ^ in_rx_byte;
      do_phase = 1'b1;
    end

    if (do_phase) begin
      phase_nxt       = phase_t_v;
      running_xor_nxt = xor_t;
      unique case (phase_t_v)
        PH_AWAIT: begin
          if (expected_seq_r != byte_v && seq_warn_enable_r) begin
            res_valid = 1'b1;
            res_code  = EV_SEQ_GAP;
          end
          expected_seq_nxt = byte_v + BYTE_W'(1);
          current_seq_nxt  = byte_v;
          fill_count_nxt   = '0;
          running_xor_nxt  = byte_v;
          phase_nxt        = PH_READ;
        end
        PH_READ: begin
          if (fill_count_r >= limit_use) begin
            res_valid       = 1'b1;
            res_code        = EV_OVERFLOW;
            phase_nxt       = PH_INVALID;
            running_xor_nxt = '0;
          end else begin
            store_we       = 1'b1;
            fill_count_nxt = fill_count_r + FILL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit_r    <= BUFFER_LIMIT_RST;
      seq_warn_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUFFER_LIMIT: buffer_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_SEQ_WARN:     seq_warn_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_AWAIT;
      escape_pending_r <= 1'b0;
      running_xor_r    <= '0;
      expected_seq_r   <= '0;
      current_seq_r    <= '0;
      fill_count_r     <= '0;
    end else if (cmd.step) begin
      phase_r          <= phase_nxt;
      escape_pending_r <= escape_pending_nxt;
      running_xor_r    <= running_xor_nxt;
      expected_seq_r   <= expected_seq_nxt;
      current_seq_r    <= current_seq_nxt;
      fill_count_r     <= fill_count_nxt;
    end
  end

  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.step && store_we),
    .waddr (fill_count_r[STORE_AW-1:0]),
    .wdata (byte_v),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_idx_r    <= '0;
      frame_len_r <= frame_len;
    end else if (cmd.rd_load) begin
      rd_idx_r <= rd_idx_r + STORE_AW'(1);
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.readout_go = readout_go;
  assign sts.rd_last    = (LEN_W'(rd_idx_r) == frame_len_r - LEN_W'(1));

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((cmd.step && res_valid) || cmd.rd_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && res_valid) begin
      kind_r <= res_kind;
      seq_r  <= (res_kind == KIND_HEADER) ? current_seq_r : '0;
      len_r  <= (res_kind == KIND_HEADER) ? frame_len : '0;
      byte_r <= '0;
      code_r <= (res_kind == KIND_EVENT) ? res_code : '0;
      last_r <= res_last;
    end else if (cmd.rd_load) begin
      kind_r <= KIND_PAYLOAD;
      seq_r  <= '0;
      len_r  <= '0;
      byte_r <= rd_data;
      code_r <= '0;
      last_r <= sts.rd_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_frame_sequence = seq_r;
  assign out_payload_length = len_r;
  assign out_payload_byte   = byte_r;
  assign out_event_code     = code_r;
  assign out_last_result    = last_r;

endmodule
